/* src/welf_pkg.sv */
// ----------------------------------------------------------------------------
// welf_pkg
// Shared widths, constants and sequencer states for the running statistics
// unit (online mean, sum of squared deviations, min and max).
// ----------------------------------------------------------------------------
package welf_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MEAN_BITS   = 48;
  localparam int COUNT_BITS  = 32;
  localparam int M2_BITS     = 64;
  localparam int OUT_BITS    = COUNT_BITS + MEAN_BITS + M2_BITS + 2 * SAMPLE_BITS;

  // Datapath widths: |delta| stays below 2^MEAN_BITS
  localparam int MAG_BITS    = MEAN_BITS;
  localparam int DELTA_BITS  = MEAN_BITS + 1;
  localparam int PROD_BITS   = 2 * MAG_BITS;

  // Divider runs one quotient bit per cycle
  localparam int DIV_STEPS   = MAG_BITS;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);

  // Multiplier works on 16-bit digits of the second operand, high digit first
  localparam int CHUNK_BITS  = 16;
  localparam int NUM_CHUNKS  = MAG_BITS / CHUNK_BITS;
  localparam int PP_BITS     = MAG_BITS + CHUNK_BITS;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MEAN,
    ST_DELTA2,
    ST_MUL,
    ST_ACC
  } state_t;

  typedef logic signed [MEAN_BITS-1:0]   mean_t;
  typedef logic signed [DELTA_BITS-1:0]  delta_t;
  typedef logic        [MAG_BITS-1:0]    mag_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;
  typedef logic        [M2_BITS-1:0]     m2_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

/* src/welford_running_stats_unit.sv */
// ----------------------------------------------------------------------------
// welford_running_stats_unit
// Online running statistics over a stream of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one signed 32-bit sample per transfer.
//   Output channel (out_*): one result per sample carrying the sample count,
//   the running mean and M2 (both with 16 fraction bits), and the minimum
//   and maximum sample seen so far.
//   Each sample passes, from input transfer to result valid, through the
//   bit-serial divider that forms delta / count, a step that moves the
//   mean, a step that forms the second deviation, the 48x16 digit
//   multiplier, and a step that adds into M2. The divider loop takes the
//   largest share of each sample's time; a new sample is taken only once
//   the previous one is through, as in_tready is high only while the
//   sequencer is idle.
//   The result sits in an output register; the next sample is accepted
//   while it waits. If the receiver stalls, the sequencer holds in its last
//   step until the output register frees up, then commits.
//   Reset clears count, mean and M2, sets the minimum to the largest sample
//   value and the maximum to the smallest, and drops out_tvalid.
// ----------------------------------------------------------------------------
module welford_running_stats_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [welf_pkg::SAMPLE_BITS-1:0]    in_tdata,   // [31:0] sample
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] sample_count, [79:32] running_mean, [143:80] sq_dev_sum,
  // [175:144] min_seen, [207:176] max_seen
  output logic [welf_pkg::OUT_BITS-1:0]       out_tdata
);

  // Architectural state
  welf_pkg::state_t                 state_r, state_nxt;
  welf_pkg::count_t                 count_r, count_nxt;
  welf_pkg::mean_t                  mean_r, mean_nxt;
  welf_pkg::m2_t                    m2_r, m2_nxt;
  welf_pkg::sample_t                min_r, min_nxt;
  welf_pkg::sample_t                max_r, max_nxt;

  // Per-item working registers
  welf_pkg::sample_t                x_r, x_nxt;
  welf_pkg::mean_t                  xs_r, xs_nxt;
  welf_pkg::mag_t                   dmag_r, dmag_nxt;     // |delta|
  logic                             dneg_r, dneg_nxt;
  welf_pkg::mag_t                   dvd_r, dvd_nxt;       // dividend / quotient
  logic [welf_pkg::COUNT_BITS-1:0]  rem_r, rem_nxt;
  logic [welf_pkg::STEP_BITS-1:0]   step_r, step_nxt;
  welf_pkg::mag_t                   d2mag_r, d2mag_nxt;   // |delta2|
  logic                             d2neg_r, d2neg_nxt;
  logic [welf_pkg::PP_BITS-1:0]     pp_r, pp_nxt;
  logic [welf_pkg::PROD_BITS-1:0]   acc_r, acc_nxt;

  // Output register
  logic                             out_valid_r, out_valid_nxt;
  logic [welf_pkg::OUT_BITS-1:0]    out_data_r, out_data_nxt;

  // Combinational helpers
  logic                             in_xfer;
  logic                             out_free;
  welf_pkg::mean_t                  xs_in;
  welf_pkg::delta_t                 delta_in;
  logic [welf_pkg::COUNT_BITS:0]    rem_sh;
  logic [welf_pkg::COUNT_BITS:0]    rem_diff;
  welf_pkg::mean_t                  q_signed;
  welf_pkg::delta_t                 delta2;
  logic [welf_pkg::CHUNK_BITS-1:0]  chunk;
  logic [welf_pkg::PROD_BITS-1:0]   prod_sh;
  welf_pkg::m2_t                    m2_add;
  logic [welf_pkg::M2_BITS:0]       m2_sum;
  logic                             opp_sign;
  logic                             d_pos, d2_pos;

  assign in_tready  = (state_r == welf_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Scaled sample and first deviation
  assign xs_in    = welf_pkg::mean_t'(signed'(in_tdata)) <<< welf_pkg::FRAC_BITS;
  assign delta_in = welf_pkg::delta_t'(xs_in) - welf_pkg::delta_t'(mean_r);

  // Restoring divider step: remainder stays below the count
  assign rem_sh   = {rem_r, dvd_r[welf_pkg::MAG_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, count_r};

  // Signed quotient and second deviation
  assign q_signed = dneg_r ? welf_pkg::mean_t'(-dvd_r) : welf_pkg::mean_t'(dvd_r);
  assign delta2   = welf_pkg::delta_t'(xs_r) - welf_pkg::delta_t'(mean_r);

  // Multiplier digit, high digit first
  always_comb begin
    unique case (step_r[1:0])
      2'd0:    chunk = d2mag_r[3*welf_pkg::CHUNK_BITS-1:2*welf_pkg::CHUNK_BITS];
      2'd1:    chunk = d2mag_r[2*welf_pkg::CHUNK_BITS-1:welf_pkg::CHUNK_BITS];
      2'd2:    chunk = d2mag_r[welf_pkg::CHUNK_BITS-1:0];
      default: chunk = '0;
    endcase
  end

  // M2 increment: truncate fraction bits, saturate, add with saturation
  assign d_pos    = !dneg_r && (dmag_r != '0);
  assign d2_pos   = !d2neg_r && (d2mag_r != '0);
  assign opp_sign = (dneg_r && d2_pos) || (d_pos && d2neg_r);
  assign prod_sh  = acc_r >> welf_pkg::FRAC_BITS;
  always_comb begin
    if (opp_sign) begin
      m2_add = '0;
    end else if (prod_sh[welf_pkg::PROD_BITS-1:welf_pkg::M2_BITS] != '0) begin
      m2_add = '1;
    end else begin
      m2_add = prod_sh[welf_pkg::M2_BITS-1:0];
    end
  end
  assign m2_sum = {1'b0, m2_r} + {1'b0, m2_add};

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mean_nxt      = mean_r;
    m2_nxt        = m2_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    x_nxt         = x_r;
    xs_nxt        = xs_r;
    dmag_nxt      = dmag_r;
    dneg_nxt      = dneg_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    d2mag_nxt     = d2mag_r;
    d2neg_nxt     = d2neg_r;
    pp_nxt        = pp_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      welf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (count_r != '1) begin
            count_nxt = count_r + welf_pkg::count_t'(1);
          end
          x_nxt    = in_tdata;
          xs_nxt   = xs_in;
          dneg_nxt = delta_in[welf_pkg::DELTA_BITS-1];
          dmag_nxt = delta_in[welf_pkg::DELTA_BITS-1] ?
                     welf_pkg::mag_t'(-delta_in) : welf_pkg::mag_t'(delta_in);
          dvd_nxt  = delta_in[welf_pkg::DELTA_BITS-1] ?
                     welf_pkg::mag_t'(-delta_in) : welf_pkg::mag_t'(delta_in);
          rem_nxt  = '0;
          step_nxt = '0;
          state_nxt = welf_pkg::ST_DIV;
        end
      end

      welf_pkg::ST_DIV: begin
        if (!rem_diff[welf_pkg::COUNT_BITS]) begin
          rem_nxt = rem_diff[welf_pkg::COUNT_BITS-1:0];
          dvd_nxt = {dvd_r[welf_pkg::MAG_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[welf_pkg::COUNT_BITS-1:0];
          dvd_nxt = {dvd_r[welf_pkg::MAG_BITS-2:0], 1'b0};
        end
        if (step_r == welf_pkg::STEP_BITS'(welf_pkg::DIV_STEPS - 1)) begin
          state_nxt = welf_pkg::ST_MEAN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      welf_pkg::ST_MEAN: begin
        mean_nxt  = mean_r + q_signed;
        state_nxt = welf_pkg::ST_DELTA2;
      end

      welf_pkg::ST_DELTA2: begin
        d2neg_nxt = delta2[welf_pkg::DELTA_BITS-1];
        d2mag_nxt = delta2[welf_pkg::DELTA_BITS-1] ?
                    welf_pkg::mag_t'(-delta2) : welf_pkg::mag_t'(delta2);
        step_nxt  = '0;
        acc_nxt   = '0;
        state_nxt = welf_pkg::ST_MUL;
      end

      welf_pkg::ST_MUL: begin
        // digit product registered, then shifted accumulate
        pp_nxt = {{welf_pkg::CHUNK_BITS{1'b0}}, dmag_r}
               * {{welf_pkg::MAG_BITS{1'b0}}, chunk};
        if (step_r != '0) begin
          acc_nxt = {acc_r[welf_pkg::PROD_BITS-welf_pkg::CHUNK_BITS-1:0],
                     {welf_pkg::CHUNK_BITS{1'b0}}}
                  + welf_pkg::PROD_BITS'(pp_r);
        end
        if (step_r == welf_pkg::STEP_BITS'(welf_pkg::NUM_CHUNKS)) begin
          state_nxt = welf_pkg::ST_ACC;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      welf_pkg::ST_ACC: begin
        if (out_free) begin
          m2_nxt  = m2_sum[welf_pkg::M2_BITS] ? '1 : m2_sum[welf_pkg::M2_BITS-1:0];
          min_nxt = (x_r < min_r) ? x_r : min_r;
          max_nxt = (x_r > max_r) ? x_r : max_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {max_nxt, min_nxt, m2_nxt, mean_r, count_r};
          state_nxt     = welf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = welf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= welf_pkg::ST_IDLE;
      count_r     <= '0;
      mean_r      <= '0;
      m2_r        <= '0;
      min_r       <= {1'b0, {(welf_pkg::SAMPLE_BITS-1){1'b1}}};
      max_r       <= {1'b1, {(welf_pkg::SAMPLE_BITS-1){1'b0}}};
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
      m2_r        <= m2_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    xs_r       <= xs_nxt;
    dmag_r     <= dmag_nxt;
    dneg_r     <= dneg_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    d2mag_r    <= d2mag_nxt;
    d2neg_r    <= d2neg_nxt;
    pp_r       <= pp_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // Divider remainder always stays below the divisor
  a_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == welf_pkg::ST_DIV) |-> (rem_r < count_r))
    else $error("divider remainder not below count");

  // Never divide by zero once an item is in flight
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != welf_pkg::ST_IDLE) |-> (count_r != '0))
    else $error("count is zero while busy");

  // M2 never decreases
  a_m2_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == welf_pkg::ST_ACC) && out_free |=> (m2_r >= $past(m2_r)))
    else $error("M2 decreased");

  // A new result only appears when the sequencer commits
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == welf_pkg::ST_ACC))
    else $error("result raised outside commit step");

endmodule

/* test/welford_running_stats_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// welford_running_stats_unit_tb
// Self-checking bench for the running statistics unit. Signed samples are
// streamed in, and each result is checked against an in-bench Welford
// predictor: count, mean, M2, min and max. Both sides idle at random in
// the first two of three phases; the bench drains between them. Wide
// samples come last because a saturated M2 stays saturated until reset.
// ----------------------------------------------------------------------------
module welford_running_stats_unit_tb;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_TICKS = 8;
  localparam int TAIL_CYCLES = 120;
  localparam int TIMEOUT_NS  = 10_000_000;

  // Result fields, in out_tdata order from the top bits down
  typedef struct packed {
    welf_pkg::sample_t max_v;
    welf_pkg::sample_t min_v;
    welf_pkg::m2_t     m2;
    welf_pkg::mean_t   mean;
    welf_pkg::count_t  count;
  } stats_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [welf_pkg::SAMPLE_BITS-1:0] in_tdata   = '0;      // [31:0] sample
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // [31:0] count, [79:32] mean, [143:80] M2, [175:144] min, [207:176] max
  logic [welf_pkg::OUT_BITS-1:0]    out_tdata;

  welf_pkg::sample_t sample_q[$];    // samples waiting for the driver
  stats_t            stats_q[$];     // expected statistics, oldest first
  logic              in_taken      = 1'b0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                mismatch_cnt  = 0;
  int                result_cnt    = 0;

  // Predictor state, same reset as the block
  welf_pkg::count_t  acc_count = '0;
  welf_pkg::mean_t   acc_mean  = '0;
  welf_pkg::m2_t     acc_m2    = '0;
  welf_pkg::sample_t acc_min   = {1'b0, {(welf_pkg::SAMPLE_BITS-1){1'b1}}};
  welf_pkg::sample_t acc_max   = {1'b1, {(welf_pkg::SAMPLE_BITS-1){1'b0}}};

  // Small and truncating cases first; the deviations stay small here
  welf_pkg::sample_t opening_samples [16] = '{
    0, 0, 1, -1, 3, -3, 7, 2, 100, -100, 65535, -65536, 32767, -32768,
    12345, -54321
  };

  welford_running_stats_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // One Welford update on the predictor state
  function automatic stats_t welford_update(input welf_pkg::sample_t x);
    longint       scaled;
    longint       dev_pre;
    longint       dev_post;
    longint       step;
    logic [63:0]  mag_pre;
    logic [63:0]  mag_post;
    logic [127:0] prod;
    logic [63:0]  m2_inc;
    logic [64:0]  m2_sum;
    stats_t       res;
    if (acc_count != '1) acc_count = acc_count + 1'b1;
    scaled  = longint'(x) <<< welf_pkg::FRAC_BITS;
    dev_pre = scaled - longint'(acc_mean);
    // signed divide truncates toward zero
    step     = dev_pre / longint'({32'd0, acc_count});
    acc_mean = welf_pkg::mean_t'(longint'(acc_mean) + step);
    dev_post = scaled - longint'(acc_mean);
    // product of magnitudes, shifted down and clamped to 64 bits
    if ((dev_pre < 0 && dev_post > 0) || (dev_pre > 0 && dev_post < 0)) begin
      m2_inc = '0;
    end else begin
      mag_pre  = (dev_pre < 0) ? -dev_pre : dev_pre;
      mag_post = (dev_post < 0) ? -dev_post : dev_post;
      prod     = ({64'd0, mag_pre} * {64'd0, mag_post}) >> welf_pkg::FRAC_BITS;
      m2_inc   = (prod[127:64] != '0) ? '1 : prod[63:0];
    end
    m2_sum = {1'b0, acc_m2} + {1'b0, m2_inc};
    acc_m2 = m2_sum[64] ? '1 : m2_sum[63:0];
    if (x < acc_min) acc_min = x;
    if (x > acc_max) acc_max = x;
    res.count = acc_count;
    res.mean  = acc_mean;
    res.m2    = acc_m2;
    res.min_v = acc_min;
    res.max_v = acc_max;
    return res;
  endfunction

  // Mostly narrow samples, a few wide ones; keeps M2 well below saturation
  function automatic welf_pkg::sample_t random_sample();
    int pick;
    int span;
    pick = $urandom_range(99, 0);
    if (pick < 20)      span = 4;
    else if (pick < 55) span = 1 << 10;
    else if (pick < 85) span = 1 << 15;
    else if (pick < 95) span = 1 << 17;
    else                span = 1 << 19;
    return welf_pkg::sample_t'(int'($urandom_range(2 * span, 0)) - span);
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) sample_q.push_back(random_sample());
  endtask

  // Nothing left to send, nothing on the wire, nothing outstanding
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_tvalid || stats_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("result %0d %s: expected %h, got %h", result_cnt, name, want, got);
    end
  endtask

  task automatic check_result(input stats_t got);
    stats_t want;
    result_cnt++;
    if (stats_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("result %0d: unexpected transfer, data %h", result_cnt, got);
    end else begin
      want = stats_q.pop_front();
      check_field("sample_count", want.count, got.count);
      check_field("running_mean", want.mean, got.mean);
      check_field("sq_dev_sum", want.m2, got.m2);
      check_field("min_seen", want.min_v, got.min_v);
      check_field("max_seen", want.max_v, got.max_v);
    end
  endtask

  // Sender: next sample once the current one is taken, with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (sample_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_tdata  <= sample_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Check results first, then predict for a newly accepted sample
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result(stats_t'(out_tdata));
      if (in_tvalid && in_tready)
        stats_q.push_back(welford_update(welf_pkg::sample_t'(in_tdata)));
    end
  end

  initial begin
    repeat (RESET_TICKS) @(negedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender idles a little, receiver a lot
    send_idle_pct = 36;
    recv_idle_pct = 85;
    foreach (opening_samples[i]) sample_q.push_back(opening_samples[i]);
    queue_random(400);
    wait_drained();

    // Phase 2: the other way round
    send_idle_pct = 85;
    recv_idle_pct = 36;
    queue_random(430);
    wait_drained();

    // Phase 3: full rate, then the sample extremes and M2 overflow
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(420);
    sample_q.push_back(32'sh7fffffff);
    sample_q.push_back(32'sh80000000);
    sample_q.push_back(32'sh80000000);
    sample_q.push_back(32'sh7fffffff);
    sample_q.push_back(0);
    sample_q.push_back(-1);
    for (int i = 0; i < 20; i++) sample_q.push_back(welf_pkg::sample_t'($urandom));
    wait_drained();

    // Catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && stats_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
